// ===== rtl/assert_macros.svh =====
// assertion macros used by cce_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CCE_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("cce check failed");

// checked at every edge, reset included
`define CCE_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) else $error("cce check failed");

`endif

// ===== rtl/cce_pkg.sv =====
package cce_pkg;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [2:0]  weekday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } cal_type;

   typedef struct packed {
      logic valid;
      logic sync_request;
   } tag_type;

   localparam cal_type CAL_RESET = '{
      year:    12'd1970,
      month:   4'd1,
      day:     5'd1,
      weekday: 3'd4,
      hour:    5'd0,
      minute:  6'd0,
      second:  6'd0
   };

   localparam logic [11:0] SYNC_INTERVAL_RESET = 12'd512;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   localparam logic [5:0]  LAST_SECOND  = 6'd59;
   localparam logic [5:0]  LAST_MINUTE  = 6'd59;
   localparam logic [4:0]  LAST_HOUR    = 5'd23;
   localparam logic [2:0]  LAST_WEEKDAY = 3'd6;
   localparam logic [3:0]  LAST_MONTH   = 4'd12;

   localparam logic [31:0] EPOCH_DAY_OFFSET = 32'd719499;
   // year one below zero, seen as 2^32-1
   localparam logic [31:0] WRAP_LEAP_SUM    = 32'd1041529569;
   localparam logic [31:0] WRAP_YEAR_DAYS   = 32'hFFFF_FE93;

   // floor(y / 100) for a 12-bit year, by reciprocal
   function automatic logic [5:0] div100(input logic [11:0] y);
      logic [24:0] p;
      p = 25'(y) * 25'd5243;
      return p[24:19];
   endfunction

   function automatic logic is_leap(input logic [11:0] y);
      logic [5:0]  q;
      logic [11:0] h;
      q = div100(y);
      h = 12'(q) * 12'd100;
      return (y[1:0] == 2'd0) && ((h != y) || (q[1:0] == 2'd0));
   endfunction

   function automatic logic [4:0] days_in_month(input logic [11:0] y,
                                                input logic [3:0] m);
      logic [4:0] d;
      case (m)
         4'd2:                     d = is_leap(y) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
         default:                  d = 5'd31;
      endcase
      return d;
   endfunction

   // 367 * shifted month / 12, march counts as month one
   function automatic logic [8:0] month_days(input logic [3:0] m);
      logic [8:0] d;
      case (m)
         4'd0:    d = 9'd305;
         4'd1:    d = 9'd336;
         4'd2:    d = 9'd367;
         4'd3:    d = 9'd30;
         4'd4:    d = 9'd61;
         4'd5:    d = 9'd91;
         4'd6:    d = 9'd122;
         4'd7:    d = 9'd152;
         4'd8:    d = 9'd183;
         4'd9:    d = 9'd214;
         4'd10:   d = 9'd244;
         4'd11:   d = 9'd275;
         4'd12:   d = 9'd305;
         4'd13:   d = 9'd336;
         4'd14:   d = 9'd367;
         default: d = 9'd397;
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/calendar_clock_with_epoch_seconds.sv =====
// channel   dir  handshake               payload
// req       in   req_tvalid/req_tready   req_tdata load calendar, req_tuser kind
// rsp       out  rsp_tvalid/rsp_tready   rsp_tdata calendar and epoch, rsp_tuser sync
// csr       in   csr_wr_en               csr_wr_data sync interval
//
// one word accepted per cycle while rsp is not stalled; the calendar updates in the accept
// cycle unless a tick raises sync; results pass calendar, days, hours, minutes, seconds regs
// a stalled rsp word freezes the whole pipeline and drops req_tready
// synchronous reset restores 1970-01-01 00:00:00 thursday and interval 512
module calendar_clock_with_epoch_seconds (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // load_year, load_month, load_day, load_weekday,
                                    // load_hour, load_minute, load_second, zero pad
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // year, month, day, weekday, hour, minute, second,
                                    // epoch_seconds, zero pad
   output logic        rsp_tuser,   // sync_request
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data
);
   import cce_pkg::*;

   logic        advance;
   logic        req_fire;
   cal_type     load_cal;
   cal_type     cal_now, cal_out;
   tag_type     tag_now, tag_out;
   logic [31:0] epoch;

   assign advance  = !rsp_tvalid || rsp_tready;
   assign req_fire = req_tvalid && advance;

   assign load_cal.year    = req_tdata[11:0];
   assign load_cal.month   = req_tdata[15:12];
   assign load_cal.day     = req_tdata[20:16];
   assign load_cal.weekday = req_tdata[23:21];
   assign load_cal.hour    = req_tdata[28:24];
   assign load_cal.minute  = req_tdata[34:29];
   assign load_cal.second  = req_tdata[40:35];

   cce_calendar u_calendar (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req_fire    (req_fire),
      .kind        (req_tuser),
      .load_cal    (load_cal),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cal         (cal_now),
      .tag         (tag_now)
   );

   cce_epoch u_epoch (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cal_i   (cal_now),
      .tag_i   (tag_now),
      .cal_o   (cal_out),
      .tag_o   (tag_out),
      .epoch_o (epoch)
   );

   assign req_tready = advance;
   assign rsp_tvalid = tag_out.valid;
   assign rsp_tuser  = tag_out.sync_request;
   assign rsp_tdata  = {7'd0, epoch, cal_out.second, cal_out.minute, cal_out.hour,
                        cal_out.weekday, cal_out.day, cal_out.month, cal_out.year};

endmodule

// ===== rtl/cce_calendar.sv =====
module cce_calendar (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            req_fire,
   input  logic            kind,
   input  cce_pkg::cal_type load_cal,
   input  logic            csr_wr_en,
   input  logic [11:0]     csr_wr_data,
   output cce_pkg::cal_type cal,
   output cce_pkg::tag_type tag
);
   import cce_pkg::*;

   cal_type     cal_ff, cal_in, tick_cal;
   tag_type     tag_ff, tag_in;
   logic [11:0] sync_cnt_ff, sync_cnt_in;
   logic [11:0] interval_ff;
   logic [12:0] sync_next;
   logic [6:0]  sec_n, min_n;
   logic [5:0]  hour_n, day_n;
   logic [3:0]  wday_n;
   logic [4:0]  mon_n;

   always_comb begin
      tick_cal = cal_ff;
      sec_n    = {1'b0, cal_ff.second} + 7'd1;
      min_n    = {1'b0, cal_ff.minute} + 7'd1;
      hour_n   = {1'b0, cal_ff.hour} + 6'd1;
      wday_n   = {1'b0, cal_ff.weekday} + 4'd1;
      day_n    = {1'b0, cal_ff.day} + 6'd1;
      mon_n    = {1'b0, cal_ff.month} + 5'd1;
      if (sec_n <= {1'b0, LAST_SECOND}) begin
         tick_cal.second = sec_n[5:0];
      end else begin
         tick_cal.second = '0;
         if (min_n <= {1'b0, LAST_MINUTE}) begin
            tick_cal.minute = min_n[5:0];
         end else begin
            tick_cal.minute = '0;
            if (hour_n <= {1'b0, LAST_HOUR}) begin
               tick_cal.hour = hour_n[4:0];
            end else begin
               tick_cal.hour    = '0;
               tick_cal.weekday = (wday_n > {1'b0, LAST_WEEKDAY}) ? 3'd0 : wday_n[2:0];
               if (day_n <= {1'b0, days_in_month(cal_ff.year, cal_ff.month)}) begin
                  tick_cal.day = day_n[4:0];
               end else begin
                  tick_cal.day = 5'd1;
                  if (mon_n <= {1'b0, LAST_MONTH}) begin
                     tick_cal.month = mon_n[3:0];
                  end else begin
                     tick_cal.month = 4'd1;
                     tick_cal.year  = cal_ff.year + 12'd1;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      cal_in      = cal_ff;
      sync_cnt_in = sync_cnt_ff;
      tag_in      = tag_ff;
      sync_next   = {1'b0, sync_cnt_ff} + 13'd1;
      if (advance) begin
         tag_in.valid        = req_fire;
         tag_in.sync_request = 1'b0;
      end
      if (req_fire) begin
         if (kind == KIND_LOAD) begin
            cal_in = load_cal;
         end else if (sync_next > {1'b0, interval_ff}) begin
            sync_cnt_in         = '0;
            tag_in.sync_request = 1'b1;
         end else begin
            sync_cnt_in = sync_next[11:0];
            cal_in      = tick_cal;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff      <= CAL_RESET;
         tag_ff      <= '0;
         sync_cnt_ff <= '0;
         interval_ff <= SYNC_INTERVAL_RESET;
      end else begin
         cal_ff      <= cal_in;
         tag_ff      <= tag_in;
         sync_cnt_ff <= sync_cnt_in;
         if (csr_wr_en) begin
            interval_ff <= csr_wr_data;
         end
      end
   end

   assign cal = cal_ff;
   assign tag = tag_ff;

endmodule

// ===== rtl/cce_epoch.sv =====
module cce_epoch (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  cce_pkg::cal_type cal_i,
   input  cce_pkg::tag_type tag_i,
   output cce_pkg::cal_type cal_o,
   output cce_pkg::tag_type tag_o,
   output logic [31:0]      epoch_o
);
   import cce_pkg::*;

   cal_type     s1_cal_ff, s2_cal_ff, s3_cal_ff, s4_cal_ff;
   tag_type     s1_tag_ff, s2_tag_ff, s3_tag_ff, s4_tag_ff;
   logic [31:0] days_ff, hours_ff, mins_ff, secs_ff;
   logic [31:0] days_in, hours_in, mins_in, secs_in;
   logic        shift, wrap;
   logic [11:0] ye;
   logic [5:0]  q;
   logic [20:0] yr_days;
   logic [31:0] leap_sum, year_days;

   // days since the epoch
   always_comb begin
      shift   = (cal_i.month <= 4'd2);
      wrap    = shift && (cal_i.year == 12'd0);
      ye      = cal_i.year - {11'd0, shift};
      q       = div100(ye);
      yr_days = 21'(ye) * 21'd365;
      if (wrap) begin
         leap_sum  = WRAP_LEAP_SUM;
         year_days = WRAP_YEAR_DAYS;
      end else begin
         leap_sum  = 32'(ye[11:2]) - 32'(q) + 32'(q[5:2]);
         year_days = 32'(yr_days);
      end
      days_in = leap_sum + 32'(month_days(cal_i.month)) + 32'(cal_i.day)
                + year_days - EPOCH_DAY_OFFSET;
   end

   assign hours_in = days_ff * 32'd24 + 32'(s1_cal_ff.hour);
   assign mins_in  = hours_ff * 32'd60 + 32'(s2_cal_ff.minute);
   assign secs_in  = mins_ff * 32'd60 + 32'(s3_cal_ff.second);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
         s4_tag_ff <= '0;
      end else if (advance) begin
         s1_tag_ff <= tag_i;
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
         s4_tag_ff <= s3_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cal_ff <= cal_i;
         s2_cal_ff <= s1_cal_ff;
         s3_cal_ff <= s2_cal_ff;
         s4_cal_ff <= s3_cal_ff;
         days_ff   <= days_in;
         hours_ff  <= hours_in;
         mins_ff   <= mins_in;
         secs_ff   <= secs_in;
      end
   end

   assign cal_o   = s4_cal_ff;
   assign tag_o   = s4_tag_ff;
   assign epoch_o = secs_ff;

endmodule

// ===== rtl/cce_checker.sv =====
`include "assert_macros.svh"

module cce_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a held word stays
   `CCE_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `CCE_ASSERT(a_rsp_stable, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
   // an empty output never blocks the input
   `CCE_ASSERT(a_ready_when_empty, !rsp_tvalid |-> req_tready)
   // reset flushes the pipeline
   `CCE_ASSERT_ALWAYS(a_reset_flush, reset |=> !rsp_tvalid)

endmodule

bind calendar_clock_with_epoch_seconds cce_checker u_cce_checker (.*);
